// ===== src/itcv_pkg.sv =====
// ----------------------------------------------------------------------------
// itcv_pkg
// Shared widths and constants for the tilt correction vector datapath.
// ----------------------------------------------------------------------------
package itcv_pkg;

    // unit vector component, signed q1.15
    localparam int UNIT_W = 16;
    localparam logic [UNIT_W-1:0] UNIT_MAX = 16'd32767;

    // normalised sum of squares and its square root
    localparam int SQ_W = 62;
    localparam int RT_W = SQ_W / 2;

    // rounded numerator of the unit division and its quotient
    localparam int NUM_W = 47;
    localparam int UQ_W  = 17;

    // normalising shift count, in pairs of bits
    localparam int M_W = 5;

endpackage

// ===== src/itcv_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// itcv_sqrt_cell
// One digit of a restoring integer square root; a chain of these cells
// resolves one root bit per cycle per cell.
// ----------------------------------------------------------------------------
module itcv_sqrt_cell #(
    parameter int RAD_W = 62,
    parameter int PAY_W = 1
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 src_valid,
    input  logic [RAD_W-1:0]     src_rad,
    input  logic [RAD_W/2+2:0]   src_rem,
    input  logic [RAD_W/2-1:0]   src_root,
    input  logic [PAY_W-1:0]     src_pay,
    output logic                 valid,
    output logic [RAD_W-1:0]     rad,
    output logic [RAD_W/2+2:0]   rem,
    output logic [RAD_W/2-1:0]   root,
    output logic [PAY_W-1:0]     pay
);

    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 3;

    logic              valid_reg;
    logic [RAD_W-1:0]  rad_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [PAY_W-1:0]  pay_reg;

    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              take;
    logic [REM_W-1:0]  rem_next;
    logic [ROOT_W-1:0] root_next;

    // bring down the next pair of radicand bits
    assign rem_sh    = {src_rem[REM_W-3:0], src_rad[RAD_W-1 -: 2]};
    assign trial     = REM_W'({src_root, 2'b01});
    assign take      = (rem_sh >= trial);
    assign rem_next  = take ? (rem_sh - trial) : rem_sh;
    assign root_next = {src_root[ROOT_W-2:0], take};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= src_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= src_rad << 2;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        pay_reg  <= src_pay;
    end

    assign valid = valid_reg;
    assign rad   = rad_reg;
    assign rem   = rem_reg;
    assign root  = root_reg;
    assign pay   = pay_reg;

endmodule

// ===== src/itcv_div_cell.sv =====
// ----------------------------------------------------------------------------
// itcv_div_cell
// One step of a restoring divider: tries the divisor shifted to quotient
// bit BIT and keeps the difference when it fits.
// ----------------------------------------------------------------------------
module itcv_div_cell #(
    parameter int NUM_W = 47,
    parameter int DVS_W = 31,
    parameter int QUO_W = 17,
    parameter int BIT   = 0,
    parameter int PAY_W = 1
)(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             src_valid,
    input  logic [NUM_W-1:0] src_rem,
    input  logic [DVS_W-1:0] src_dvs,
    input  logic [QUO_W-1:0] src_quo,
    input  logic [PAY_W-1:0] src_pay,
    output logic             valid,
    output logic [NUM_W-1:0] rem,
    output logic [DVS_W-1:0] dvs,
    output logic [QUO_W-1:0] quo,
    output logic [PAY_W-1:0] pay
);

    localparam int CMP_W = (NUM_W > DVS_W + BIT) ? NUM_W : DVS_W + BIT;

    logic             valid_reg;
    logic [NUM_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [QUO_W-1:0] quo_reg;
    logic [PAY_W-1:0] pay_reg;

    logic [CMP_W-1:0] rem_w;
    logic [CMP_W-1:0] sub_w;
    logic             take;
    logic [NUM_W-1:0] rem_next;
    logic [QUO_W-1:0] quo_next;

    assign rem_w    = CMP_W'(src_rem);
    assign sub_w    = CMP_W'(src_dvs) << BIT;
    assign take     = (rem_w >= sub_w);
    assign rem_next = take ? NUM_W'(rem_w - sub_w) : src_rem;
    assign quo_next = src_quo | (QUO_W'(take) << BIT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= src_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= src_dvs;
        quo_reg <= quo_next;
        pay_reg <= src_pay;
    end

    assign valid = valid_reg;
    assign rem   = rem_reg;
    assign dvs   = dvs_reg;
    assign quo   = quo_reg;
    assign pay   = pay_reg;

endmodule

// ===== src/itcv_unit.sv =====
// ----------------------------------------------------------------------------
// itcv_unit
// Scales one signed vector to unit length in q1.15: sum of squares,
// normalising shift, square root chain and three divider chains.
// ----------------------------------------------------------------------------
module itcv_unit
    import itcv_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
)(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          src_valid,
    input  logic signed [SAMPLE_BITS-1:0] vec_x,
    input  logic signed [SAMPLE_BITS-1:0] vec_y,
    input  logic signed [SAMPLE_BITS-1:0] vec_z,
    output logic                          valid,
    output logic signed [UNIT_W-1:0]      unit_x,
    output logic signed [UNIT_W-1:0]      unit_y,
    output logic signed [UNIT_W-1:0]      unit_z,
    output logic                          zero
);

    localparam int MAG_W  = SAMPLE_BITS;
    localparam int SQR_W  = 2 * SAMPLE_BITS;
    localparam int PAY_W  = 1 + 3 + 3 * MAG_W;
    localparam int SPAY_W = PAY_W + M_W;
    localparam int NSH    = 5;

    logic signed [SAMPLE_BITS-1:0] vin [3];

    // squares and magnitudes
    logic                s1_valid_reg;
    logic [SQR_W-1:0]    sq_reg [3];
    logic [MAG_W-1:0]    mag_reg [3];
    logic [2:0]          sgn_reg;

    // sum and normalising shift stages
    logic [NSH:0]        fvld_reg;
    logic [SQ_W-1:0]     nrm_reg [NSH+1];
    logic [M_W-1:0]      shf_reg [NSH+1];
    logic [PAY_W-1:0]    fpay_reg [NSH+1];

    // square root chain
    logic [RT_W:0]       sr_vld;
    logic [SQ_W-1:0]     sr_rad [RT_W+1];
    logic [RT_W+2:0]     sr_rem [RT_W+1];
    logic [RT_W-1:0]     sr_root [RT_W+1];
    logic [SPAY_W-1:0]   sr_pay [RT_W+1];

    logic [PAY_W-1:0]    sq_pay;
    logic [M_W-1:0]      sq_shf;

    // rounded numerators
    logic                nvld_reg;
    logic [NUM_W-1:0]    num_reg [3];
    logic [RT_W-1:0]     len_reg;
    logic [2:0]          nsgn_reg;
    logic                nzero_reg;

    // divider chains
    logic [UQ_W:0]       dv_vld [3];
    logic [NUM_W-1:0]    dv_rem [3][UQ_W+1];
    logic [RT_W-1:0]     dv_dvs [3][UQ_W+1];
    logic [UQ_W-1:0]     dv_quo [3][UQ_W+1];
    logic [1:0]          dv_pay [3][UQ_W+1];

    // clamp and sign
    logic                cvld_reg;
    logic [UNIT_W-1:0]   cu_reg [3];
    logic                czero_reg;

    assign vin[0] = vec_x;
    assign vin[1] = vec_y;
    assign vin[2] = vec_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fvld_reg     <= '0;
            nvld_reg     <= 1'b0;
            cvld_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= src_valid;
            fvld_reg     <= {fvld_reg[NSH-1:0], s1_valid_reg};
            nvld_reg     <= sr_vld[RT_W];
            cvld_reg     <= dv_vld[0][UQ_W];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            sq_reg[i]  <= SQR_W'(vin[i] * vin[i]);
            mag_reg[i] <= vin[i][SAMPLE_BITS-1] ? MAG_W'(-vin[i]) : MAG_W'(vin[i]);
            sgn_reg[i] <= vin[i][SAMPLE_BITS-1];
        end

        nrm_reg[0]  <= SQ_W'(sq_reg[0]) + SQ_W'(sq_reg[1]) + SQ_W'(sq_reg[2]);
        shf_reg[0]  <= '0;
        fpay_reg[0] <= {(sq_reg[0] == '0) && (sq_reg[1] == '0) && (sq_reg[2] == '0),
                        sgn_reg, mag_reg[2], mag_reg[1], mag_reg[0]};

        // greedy shift by 32, 16, 8, 4, 2 bits keeps the word below 2^62
        for (int j = 0; j < NSH; j++)
        begin
            if (nrm_reg[j] < (SQ_W'(1) << (SQ_W - (32 >> j))))
            begin
                nrm_reg[j+1] <= nrm_reg[j] << (32 >> j);
                shf_reg[j+1] <= shf_reg[j] + M_W'(16 >> j);
            end
            else
            begin
                nrm_reg[j+1] <= nrm_reg[j];
                shf_reg[j+1] <= shf_reg[j];
            end
            fpay_reg[j+1] <= fpay_reg[j];
        end
    end

    assign sr_vld[0]  = fvld_reg[NSH];
    assign sr_rad[0]  = nrm_reg[NSH];
    assign sr_rem[0]  = '0;
    assign sr_root[0] = '0;
    assign sr_pay[0]  = {fpay_reg[NSH], shf_reg[NSH]};

    for (genvar k = 0; k < RT_W; k++)
    begin : g_sqrt
        itcv_sqrt_cell #(
            .RAD_W (SQ_W),
            .PAY_W (SPAY_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .src_valid (sr_vld[k]),
            .src_rad   (sr_rad[k]),
            .src_rem   (sr_rem[k]),
            .src_root  (sr_root[k]),
            .src_pay   (sr_pay[k]),
            .valid     (sr_vld[k+1]),
            .rad       (sr_rad[k+1]),
            .rem       (sr_rem[k+1]),
            .root      (sr_root[k+1]),
            .pay       (sr_pay[k+1])
        );
    end

    assign sq_pay = sr_pay[RT_W][SPAY_W-1:M_W];
    assign sq_shf = sr_pay[RT_W][M_W-1:0];

    // numerator is |v| * 2^(m+15) plus half the length, for round to nearest
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            num_reg[i] <= (NUM_W'(sq_pay[MAG_W*i +: MAG_W]) << ({1'b0, sq_shf} + 6'd15))
                          + NUM_W'(sr_root[RT_W] >> 1);
        end
        len_reg   <= sr_root[RT_W];
        nsgn_reg  <= sq_pay[3*MAG_W +: 3];
        nzero_reg <= sq_pay[PAY_W-1];
    end

    for (genvar i = 0; i < 3; i++)
    begin : g_comp
        assign dv_vld[i][0] = nvld_reg;
        assign dv_rem[i][0] = num_reg[i];
        assign dv_dvs[i][0] = len_reg;
        assign dv_quo[i][0] = '0;
        assign dv_pay[i][0] = {nzero_reg, nsgn_reg[i]};

        for (genvar k = 0; k < UQ_W; k++)
        begin : g_div
            itcv_div_cell #(
                .NUM_W (NUM_W),
                .DVS_W (RT_W),
                .QUO_W (UQ_W),
                .BIT   (UQ_W - 1 - k),
                .PAY_W (2)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .src_valid (dv_vld[i][k]),
                .src_rem   (dv_rem[i][k]),
                .src_dvs   (dv_dvs[i][k]),
                .src_quo   (dv_quo[i][k]),
                .src_pay   (dv_pay[i][k]),
                .valid     (dv_vld[i][k+1]),
                .rem       (dv_rem[i][k+1]),
                .dvs       (dv_dvs[i][k+1]),
                .quo       (dv_quo[i][k+1]),
                .pay       (dv_pay[i][k+1])
            );
        end
    end

    // hold a component that rounds to one at the largest q1.15 value
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            logic [UNIT_W-1:0] cm;
            cm = (dv_quo[i][UQ_W] > UQ_W'(UNIT_MAX)) ? UNIT_MAX
                                                     : UNIT_W'(dv_quo[i][UQ_W]);
            cu_reg[i] <= dv_pay[i][UQ_W][0] ? (~cm + 1'b1) : cm;
        end
        czero_reg <= dv_pay[0][UQ_W][1];
    end

    assign valid  = cvld_reg;
    assign unit_x = cu_reg[0];
    assign unit_y = cu_reg[1];
    assign unit_z = cu_reg[2];
    assign zero   = czero_reg;

    a_root_exact: assert property (@(posedge clk) disable iff (!rst_n)
        sr_vld[RT_W] |-> (sr_rem[RT_W] <= {sr_root[RT_W], 1'b0}) && (sr_rad[RT_W] == '0))
        else $error("square root remainder out of range");

    a_div_lanes: assert property (@(posedge clk) disable iff (!rst_n)
        (dv_vld[0][UQ_W] == dv_vld[1][UQ_W]) && (dv_vld[0][UQ_W] == dv_vld[2][UQ_W]))
        else $error("divider lanes out of step");

    for (genvar i = 0; i < 3; i++)
    begin : g_chk
        a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
            dv_vld[i][UQ_W] && !dv_pay[i][UQ_W][1]
            |-> dv_rem[i][UQ_W] < NUM_W'(dv_dvs[i][UQ_W]))
            else $error("unit divider remainder not below divisor");
    end

endmodule

// ===== src/imu_tilt_correction_vector.sv =====
// ----------------------------------------------------------------------------
// imu_tilt_correction_vector
// Correction axis between an accelerometer vector and an estimated gravity
// vector, scaled to a length of 2*sin(half angle), signed q3.17.
// ----------------------------------------------------------------------------
// A beat is taken on every rising edge with start high; busy is always low,
// so a new vector pair may be offered on every cycle. Both vectors are
// SAMPLE_BITS wide signed counts on the same scale.
// Each beat gives exactly one result on corr_x, corr_y, corr_z and
// zero_vector, shown for one cycle with done high, and one result can leave
// on every cycle. The pipeline is built from the cell chains: 31 root cells
// and 17 divider cells for the unit vectors, then 50 divider cells and 25
// root cells for the scale, plus 14 stages of squares, shifts, products and
// rounding.
// If either vector is all zero, zero_vector is high and the axis is zero.
// Reset clears only the valid bits of the pipeline; beats in flight are
// dropped. The receiver has no way to hold off a result.
// ----------------------------------------------------------------------------
module imu_tilt_correction_vector
    import itcv_pkg::*;
#(
    parameter int SAMPLE_BITS   = 16,
    parameter int OUT_FRAC_BITS = 17
)(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [SAMPLE_BITS-1:0] acc_x,
    input  logic signed [SAMPLE_BITS-1:0] acc_y,
    input  logic signed [SAMPLE_BITS-1:0] acc_z,
    input  logic signed [SAMPLE_BITS-1:0] est_x,
    input  logic signed [SAMPLE_BITS-1:0] est_y,
    input  logic signed [SAMPLE_BITS-1:0] est_z,
    output logic                          done,
    output logic signed [19:0]            corr_x,
    output logic signed [19:0]            corr_y,
    output logic signed [19:0]            corr_z,
    output logic                          zero_vector
);

    localparam int OUT_W     = 20;
    localparam int PRD_W     = 2 * UNIT_W;
    localparam int CRS_W     = PRD_W + 1;
    localparam int DOT_W     = PRD_W + 2;
    localparam int DF_W      = DOT_W + 2;
    localparam int D_W       = 33;
    localparam int CM_W      = 32;
    localparam int LN_W      = 64;
    localparam int LQ_W      = 50;
    localparam int S_W       = LQ_W / 2;
    localparam int CPAY_W    = 1 + 3 + 3 * CM_W;
    localparam int MP_W      = CM_W + S_W;
    localparam int RND_W     = MP_W + 1;
    localparam int TOL_LSB   = 10737;
    localparam int PROD_FRAC = 46;
    localparam int SH        = PROD_FRAC - OUT_FRAC_BITS;
    localparam int LAT       = 137;

    localparam logic signed [DF_W-1:0] D_BIAS = DF_W'((64'sd1 << 30) + TOL_LSB);
    localparam logic signed [DF_W-1:0] D_MIN  = DF_W'(TOL_LSB);

    logic                     ua_valid, ue_valid;
    logic                     ua_zero, ue_zero;
    logic signed [UNIT_W-1:0] ua [3];
    logic signed [UNIT_W-1:0] ue [3];

    logic [2:0]               tvld_reg;
    logic [2:0]               tzero_reg;
    logic signed [PRD_W-1:0]  prd_reg [3][3];
    logic signed [CRS_W-1:0]  crs_reg [3];
    logic signed [DOT_W-1:0]  dot_reg;
    logic [D_W-1:0]           d_reg;
    logic [CM_W-1:0]          cmag_reg [3];
    logic [2:0]               csgn_reg;
    logic signed [DF_W-1:0]   d_full;

    logic [LQ_W:0]            ld_vld;
    logic [LN_W-1:0]          ld_rem [LQ_W+1];
    logic [D_W-1:0]           ld_dvs [LQ_W+1];
    logic [LQ_W-1:0]          ld_quo [LQ_W+1];
    logic [CPAY_W-1:0]        ld_pay [LQ_W+1];

    logic [S_W:0]             sr_vld;
    logic [LQ_W-1:0]          sr_rad [S_W+1];
    logic [S_W+2:0]           sr_rem [S_W+1];
    logic [S_W-1:0]           sr_root [S_W+1];
    logic [CPAY_W-1:0]        sr_pay [S_W+1];

    logic                     mvld_reg;
    logic [MP_W-1:0]          mulp_reg [3];
    logic [2:0]               msgn_reg;
    logic                     mzero_reg;

    logic                     done_reg;
    logic [OUT_W-1:0]         corr_reg [3];
    logic                     zv_reg;
    logic [OUT_W-1:0]         corr_next [3];

    assign busy = 1'b0;

    itcv_unit #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_unit_acc (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (start),
        .vec_x     (acc_x),
        .vec_y     (acc_y),
        .vec_z     (acc_z),
        .valid     (ua_valid),
        .unit_x    (ua[0]),
        .unit_y    (ua[1]),
        .unit_z    (ua[2]),
        .zero      (ua_zero)
    );

    itcv_unit #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_unit_est (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (start),
        .vec_x     (est_x),
        .vec_y     (est_y),
        .vec_z     (est_z),
        .valid     (ue_valid),
        .unit_x    (ue[0]),
        .unit_y    (ue[1]),
        .unit_z    (ue[2]),
        .zero      (ue_zero)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tvld_reg <= '0;
            mvld_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            tvld_reg <= {tvld_reg[1:0], ua_valid};
            mvld_reg <= sr_vld[S_W];
            done_reg <= mvld_reg;
        end
    end

    // denominator 1 + cos + tol in q2.30, kept at least one tolerance step
    assign d_full = DF_W'(dot_reg) + D_BIAS;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                prd_reg[i][j] <= PRD_W'(ua[i] * ue[j]);
            end
        end
        tzero_reg <= {tzero_reg[1:0], ua_zero | ue_zero};

        crs_reg[0] <= CRS_W'(prd_reg[1][2]) - CRS_W'(prd_reg[2][1]);
        crs_reg[1] <= CRS_W'(prd_reg[2][0]) - CRS_W'(prd_reg[0][2]);
        crs_reg[2] <= CRS_W'(prd_reg[0][1]) - CRS_W'(prd_reg[1][0]);
        dot_reg    <= DOT_W'(prd_reg[0][0]) + DOT_W'(prd_reg[1][1]) + DOT_W'(prd_reg[2][2]);

        d_reg <= (d_full < D_MIN) ? D_W'(D_MIN) : D_W'(d_full);
        for (int i = 0; i < 3; i++)
        begin
            cmag_reg[i] <= crs_reg[i][CRS_W-1] ? CM_W'(-crs_reg[i]) : CM_W'(crs_reg[i]);
            csgn_reg[i] <= crs_reg[i][CRS_W-1];
        end
    end

    // 2^63 / d, one quotient bit per cell
    assign ld_vld[0] = tvld_reg[2];
    assign ld_rem[0] = LN_W'(1) << (LN_W - 1);
    assign ld_dvs[0] = d_reg;
    assign ld_quo[0] = '0;
    assign ld_pay[0] = {tzero_reg[2], csgn_reg, cmag_reg[2], cmag_reg[1], cmag_reg[0]};

    for (genvar k = 0; k < LQ_W; k++)
    begin : g_ldiv
        itcv_div_cell #(
            .NUM_W (LN_W),
            .DVS_W (D_W),
            .QUO_W (LQ_W),
            .BIT   (LQ_W - 1 - k),
            .PAY_W (CPAY_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .src_valid (ld_vld[k]),
            .src_rem   (ld_rem[k]),
            .src_dvs   (ld_dvs[k]),
            .src_quo   (ld_quo[k]),
            .src_pay   (ld_pay[k]),
            .valid     (ld_vld[k+1]),
            .rem       (ld_rem[k+1]),
            .dvs       (ld_dvs[k+1]),
            .quo       (ld_quo[k+1]),
            .pay       (ld_pay[k+1])
        );
    end

    // square root of the quotient gives the scale in q.16
    assign sr_vld[0]  = ld_vld[LQ_W];
    assign sr_rad[0]  = ld_quo[LQ_W];
    assign sr_rem[0]  = '0;
    assign sr_root[0] = '0;
    assign sr_pay[0]  = ld_pay[LQ_W];

    for (genvar k = 0; k < S_W; k++)
    begin : g_sqrt
        itcv_sqrt_cell #(
            .RAD_W (LQ_W),
            .PAY_W (CPAY_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .src_valid (sr_vld[k]),
            .src_rad   (sr_rad[k]),
            .src_rem   (sr_rem[k]),
            .src_root  (sr_root[k]),
            .src_pay   (sr_pay[k]),
            .valid     (sr_vld[k+1]),
            .rad       (sr_rad[k+1]),
            .rem       (sr_rem[k+1]),
            .root      (sr_root[k+1]),
            .pay       (sr_pay[k+1])
        );
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            mulp_reg[i] <= MP_W'(sr_pay[S_W][CM_W*i +: CM_W]) * MP_W'(sr_root[S_W]);
        end
        msgn_reg  <= sr_pay[S_W][3*CM_W +: 3];
        mzero_reg <= sr_pay[S_W][CPAY_W-1];
    end

    // round half away from zero, then saturate to the signed output range; a zero vector flag forces zero
    always_comb
    begin
        logic [RND_W-1:0] rnd;
        logic [RND_W-1:0] rmag;
        logic [RND_W-1:0] lim;
        logic [RND_W-1:0] cl;
        lim = RND_W'(1) << (OUT_W - 1);
        for (int i = 0; i < 3; i++)
        begin
            rnd  = RND_W'(mulp_reg[i]) + (RND_W'(1) << (SH - 1));
            rmag = rnd >> SH;
            if (msgn_reg[i])
            begin
                cl = (rmag > lim) ? lim : rmag;
                corr_next[i] = OUT_W'(RND_W'(0) - cl);
            end
            else
            begin
                cl = (rmag > lim - 1'b1) ? (lim - 1'b1) : rmag;
                corr_next[i] = OUT_W'(cl);
            end
            if (mzero_reg)
            begin
                corr_next[i] = '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            corr_reg[i] <= corr_next[i];
        end
        zv_reg <= mzero_reg;
    end

    assign done        = done_reg;
    assign corr_x      = corr_reg[0];
    assign corr_y      = corr_reg[1];
    assign corr_z      = corr_reg[2];
    assign zero_vector = zv_reg;

    a_units_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        ua_valid == ue_valid)
        else $error("unit vector pipelines out of step");

    a_beat_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##LAT done)
        else $error("start beat without result");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LAT))
        else $error("result without start beat");

    a_zero_axis: assert property (@(posedge clk) disable iff (!rst_n)
        done && zero_vector |-> (corr_x == '0) && (corr_y == '0) && (corr_z == '0))
        else $error("zero vector flag with nonzero axis");

    a_ldiv_rem: assert property (@(posedge clk) disable iff (!rst_n)
        ld_vld[LQ_W] |-> (ld_rem[LQ_W] < LN_W'(ld_dvs[LQ_W])) && (ld_dvs[LQ_W] >= D_W'(TOL_LSB)))
        else $error("scale divider remainder out of range");

    a_scale_root: assert property (@(posedge clk) disable iff (!rst_n)
        sr_vld[S_W] |-> (sr_rem[S_W] <= {sr_root[S_W], 1'b0}) && (sr_rad[S_W] == '0))
        else $error("scale square root remainder out of range");

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for imu_tilt_correction_vector: random and directed
// vector pairs are driven, expected correction axes are computed in the bench
// and compared beat by beat against the pipelined results.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int SB       = 16;
    localparam int OFB      = 17;
    localparam int OW       = 20;
    localparam int TOL      = 10737;
    localparam int WD_LIMIT = 2000;

    typedef struct packed {
        logic signed [OW-1:0] x;
        logic signed [OW-1:0] y;
        logic signed [OW-1:0] z;
        logic                 zv;
    } axis_t;

    typedef logic signed [SB-1:0] vec_t [3];

    class axis_board;
        axis_t pending[$];
        int    errors;

        static function longint unsigned root64(longint unsigned v);
            longint unsigned res;
            longint unsigned bt;
            res = 0;
            bt  = 64'd1 << 62;
            while (bt > v)
                bt >>= 2;
            while (bt != 0)
            begin
                if (v >= res + bt)
                begin
                    v  -= res + bt;
                    res = (res >> 1) + bt;
                end
                else
                    res >>= 1;
                bt >>= 2;
            end
            return res;
        endfunction

        static function longint unsigned mag(longint v);
            return v < 0 ? -v : v;
        endfunction

        static function void unit_vec(input longint v[3], input longint unsigned sq,
                                      output longint u[3]);
            int              m;
            longint unsigned len;
            longint unsigned q;
            m = 0;
            while (sq < (64'd1 << 60))
            begin
                sq <<= 2;
                m++;
            end
            len = root64(sq);
            for (int i = 0; i < 3; i++)
            begin
                q = (((mag(v[i]) << m) << 15) + len / 2) / len;
                if (q > 32767)
                    q = 32767;
                u[i] = v[i] < 0 ? -longint'(q) : longint'(q);
            end
        endfunction

        static function logic signed [OW-1:0] round_sat(longint c, longint unsigned s);
            longint unsigned r;
            int              sh;
            sh = 46 - OFB;
            r  = (mag(c) * s + (64'd1 << (sh - 1))) >> sh;
            if (c < 0)
            begin
                if (r > (64'd1 << (OW - 1)))
                    r = 64'd1 << (OW - 1);
                return OW'(64'd0 - r);
            end
            if (r > (64'd1 << (OW - 1)) - 1)
                r = (64'd1 << (OW - 1)) - 1;
            return OW'(r);
        endfunction

        function void note_beat(vec_t acc, vec_t est);
            longint          a[3], e[3], ua[3], ue[3], cr[3];
            longint unsigned sa, se, s;
            longint          dot, d;
            axis_t           r;
            sa = 0;
            se = 0;
            for (int i = 0; i < 3; i++)
            begin
                a[i] = acc[i];
                e[i] = est[i];
                sa  += a[i] * a[i];
                se  += e[i] * e[i];
            end
            if (sa == 0 || se == 0)
            begin
                r = '{x: '0, y: '0, z: '0, zv: 1'b1};
                pending.push_back(r);
                return;
            end
            unit_vec(a, sa, ua);
            unit_vec(e, se, ue);
            cr[0] = ua[1] * ue[2] - ua[2] * ue[1];
            cr[1] = ua[2] * ue[0] - ua[0] * ue[2];
            cr[2] = ua[0] * ue[1] - ua[1] * ue[0];
            dot   = ua[0] * ue[0] + ua[1] * ue[1] + ua[2] * ue[2];
            d     = (64'sd1 << 30) + dot + TOL;
            if (d < TOL)
                d = TOL;
            s = root64((64'd1 << 63) / longint'(d));
            r.x  = round_sat(cr[0], s);
            r.y  = round_sat(cr[1], s);
            r.z  = round_sat(cr[2], s);
            r.zv = 1'b0;
            pending.push_back(r);
        endfunction

        task check_result(axis_t got);
            axis_t want;
            if (pending.size() == 0)
            begin
                report_mismatch("result with nothing outstanding", 0, 0);
                return;
            end
            want = pending.pop_front();
            if (got.x !== want.x)
                report_mismatch("corr_x", got.x, want.x);
            if (got.y !== want.y)
                report_mismatch("corr_y", got.y, want.y);
            if (got.z !== want.z)
                report_mismatch("corr_z", got.z, want.z);
            if (got.zv !== want.zv)
                report_mismatch("zero_vector", got.zv, want.zv);
        endtask

        task report_mismatch(string what, longint got, longint want);
            $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
            errors++;
        endtask
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic signed [SB-1:0] acc_x, acc_y, acc_z, est_x, est_y, est_z;
    logic                 done;
    logic signed [OW-1:0] corr_x, corr_y, corr_z;
    logic                 zero_vector;

    axis_board board;
    int        stall_cycles = 0;
    bit        no_gaps;

    imu_tilt_correction_vector #(
        .SAMPLE_BITS   (SB),
        .OUT_FRAC_BITS (OFB)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .acc_x       (acc_x),
        .acc_y       (acc_y),
        .acc_z       (acc_z),
        .est_x       (est_x),
        .est_y       (est_y),
        .est_z       (est_z),
        .done        (done),
        .corr_x      (corr_x),
        .corr_y      (corr_y),
        .corr_z      (corr_z),
        .zero_vector (zero_vector)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #6 clk = ~clk;
    end

    // result side and watchdog
    always @(posedge clk)
    begin
        if (rst_n && done)
            board.check_result('{x: corr_x, y: corr_y, z: corr_z, zv: zero_vector});
        if ((start && !busy) || done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    always @(posedge clk)
    begin
        if (stall_cycles > WD_LIMIT)
        begin
            $display("[imu_tilt_correction_vector] ERROR");
            $finish;
        end
    end

    // one beat; idles at random first unless in the no-gap stretch
    task send_pair(vec_t acc, vec_t est);
        while (!no_gaps && $urandom_range(99) < 12)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        acc_x <= acc[0];
        acc_y <= acc[1];
        acc_z <= acc[2];
        est_x <= est[0];
        est_y <= est[1];
        est_z <= est[2];
        @(posedge clk);
        while (busy)
            @(posedge clk);
        board.note_beat(acc, est);
        @(negedge clk);
    endtask

    task send_vals(int ax, int ay, int az, int ex, int ey, int ez);
        vec_t a, e;
        a = '{SB'(ax), SB'(ay), SB'(az)};
        e = '{SB'(ex), SB'(ey), SB'(ez)};
        send_pair(a, e);
    endtask

    function automatic logic signed [SB-1:0] rand_comp(int mode);
        case (mode)
            0: return SB'($urandom);
            1: return SB'($signed($urandom_range(64)) - 32);
            2: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
            default: return SB'($urandom_range(1) ? $urandom_range(32767, 20000)
                                                 : -$urandom_range(32768, 20000));
        endcase
    endfunction

    initial
    begin
        vec_t       a, e;
        int         mode;
        logic [1:0] pick;
        board  = new();
        no_gaps = 1'b0;
        start  = 1'b0;
        acc_x  = '0; acc_y = '0; acc_z = '0;
        est_x  = '0; est_y = '0; est_z = '0;
        rst_n  = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n  = 1'b1;

        // zero length, extremes, aligned, opposite, orthogonal
        send_vals(0, 0, 0, 100, 0, 0);
        send_vals(5, 0, 0, 0, 0, 0);
        send_vals(0, 0, 0, 0, 0, 0);
        send_vals(32767, 32767, 32767, 32767, 32767, 32767);
        send_vals(-32768, -32768, -32768, -32768, -32768, -32768);
        send_vals(32767, 0, 0, -32768, 0, 0);
        send_vals(1, 0, 0, -1, 0, 0);
        send_vals(0, 0, 1, 0, 0, -1);
        send_vals(1, 1, 1, -1, -1, -1);
        send_vals(1000, 1, 0, -1000, 0, 0);
        send_vals(32767, 0, 0, 0, 32767, 0);
        send_vals(0, -32768, 0, 0, 0, 32767);
        send_vals(-32768, 32767, -32768, 32767, -32768, 32767);
        send_vals(1, 0, 0, 0, 1, 0);
        send_vals(0, 0, 16384, 1, 0, 16384);
        send_vals(-1, -1, -1, 1, 1, 0);
        send_vals(-21846, 21845, -1, 12345, -23456, 7);

        // let the pipeline drain completely before the random part
        start <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        @(negedge clk);

        for (int n = 0; n < 700; n++)
        begin
            no_gaps = (n >= 200 && n < 320);
            mode = $urandom_range(9);
            for (int i = 0; i < 3; i++)
            begin
                a[i] = rand_comp(mode % 4);
                e[i] = rand_comp($urandom_range(3));
            end
            // near-opposite pairs hit the clamped denominator
            if (mode == 9)
            begin
                for (int i = 0; i < 3; i++)
                    e[i] = (a[i] == 16'sh8000)
                         ? 16'sh7fff
                         : SB'(-a[i] + $signed(SB'($urandom_range(2))) - 1);
            end
            else if (mode == 8)
            begin
                pick    = 2'($urandom_range(2));
                e[pick] = (e[0] == 0) ? 16'sh0 : e[0];
            end
            send_pair(a, e);
        end
        start <= 1'b0;

        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);
        if (board.errors == 0)
            $display("[imu_tilt_correction_vector] OK");
        else
            $display("[imu_tilt_correction_vector] ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
src/itcv_pkg.sv
src/itcv_sqrt_cell.sv
src/itcv_div_cell.sv
src/itcv_unit.sv
src/imu_tilt_correction_vector.sv
tb/sv/tb_top.sv
